>>> rtl/trffv_pkg.sv
// trffv_pkg: types and constants shared by the triple range frame filter and vote unit.
// Depends on nothing; used by trffv_frame, trffv_vote and the top level.

package trffv_pkg;

	localparam int FRAME_BYTES  = 9;
	localparam int SENSOR_COUNT = 3;
	localparam int DIST_W       = 16;

	localparam logic [3:0]        LAST_BYTE = 4'(FRAME_BYTES - 1);
	localparam logic [DIST_W-1:0] NONE_DIST = 16'hffff;

	typedef enum logic [1:0] {
		ACT_BYTE  = 2'd0,
		ACT_FAIL  = 2'd1,
		ACT_ROUND = 2'd2
	} action_t;

	typedef enum logic [2:0] {
		REG_HEADER    = 3'd0,
		REG_MIN_DIST  = 3'd1,
		REG_MAX_SPAN  = 3'd2,
		REG_HYST      = 3'd3,
		REG_MAX_JUMP  = 3'd4
	} reg_index_t;

	typedef struct packed {
		logic [1:0] action;
		logic [1:0] sensor;
		logic [7:0] data_byte;
	} item_t;

	typedef struct packed {
		logic [DIST_W-1:0] distance;
		logic              chosen;
	} result_t;

	// what the frame collector reports when the ninth byte lands
	typedef struct packed {
		logic              done;
		logic              hdr_ok;
		logic              sum_ok;
		logic [DIST_W-1:0] frame_dist;
	} frame_evt_t;

	typedef logic [SENSOR_COUNT-1:0][DIST_W-1:0] dist_vec_t;

endpackage

>>> rtl/trffv_frame.sv
// trffv_frame: byte-wise collector for 9-byte range frames (header, sum, distance bytes).
// Depends on trffv_pkg.

module trffv_frame (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   step,
	input  trffv_pkg::item_t       item,
	input  logic [7:0]             header_byte,
	output trffv_pkg::frame_evt_t  evt
);

	logic [3:0] count_q;
	logic [7:0] sum_q;
	logic       hdr_good_q;
	logic [7:0] low_q;
	logic [7:0] high_q;

	logic is_byte;
	logic is_clear;
	logic is_last;

	assign is_byte  = item.action == trffv_pkg::ACT_BYTE;
	assign is_clear = item.action == trffv_pkg::ACT_FAIL || item.action == trffv_pkg::ACT_ROUND;
	assign is_last  = count_q == trffv_pkg::LAST_BYTE;

	always_comb begin
		evt.done       = step && is_byte && is_last;
		evt.hdr_ok     = hdr_good_q;
		evt.sum_ok     = item.data_byte == sum_q;
		evt.frame_dist = {high_q, low_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			sum_q      <= '0;
			hdr_good_q <= 1'b1;
			low_q      <= '0;
			high_q     <= '0;
		end else if (step) begin
			if ((is_byte && is_last) || is_clear) begin
				count_q    <= '0;
				sum_q      <= '0;
				hdr_good_q <= 1'b1;
				low_q      <= '0;
				high_q     <= '0;
			end else if (is_byte) begin
				if (count_q < 4'd2 && item.data_byte != header_byte)
					hdr_good_q <= 1'b0;
				if (count_q == 4'd2)
					low_q <= item.data_byte;
				if (count_q == 4'd3)
					high_q <= item.data_byte;
				sum_q   <= sum_q + item.data_byte;
				count_q <= count_q + 4'd1;
			end
		end
	end

endmodule

>>> rtl/trffv_vote.sv
// trffv_vote: end-of-round vote over the three stored sensor distances.
// Depends on trffv_pkg.

module trffv_vote (
	input  trffv_pkg::dist_vec_t                sensor_dist,
	input  logic [trffv_pkg::SENSOR_COUNT-1:0]  updated,
	input  logic [trffv_pkg::DIST_W-1:0]        last_choice,
	input  logic [trffv_pkg::DIST_W-1:0]        max_jump,
	output trffv_pkg::result_t                  res
);

	logic [1:0]                  w;
	logic [trffv_pkg::DIST_W-1:0] dw;
	logic [trffv_pkg::DIST_W-1:0] diff;

	// last-updated sensor is the highest flagged index
	always_comb begin
		if (updated[2])
			w = 2'd2;
		else if (updated[1])
			w = 2'd1;
		else
			w = 2'd0;
	end

	assign dw   = sensor_dist[w];
	assign diff = (dw >= last_choice) ? dw - last_choice : last_choice - dw;

	always_comb begin
		res.distance = trffv_pkg::NONE_DIST;
		res.chosen   = 1'b0;
		if (|updated) begin
			if (sensor_dist[0] == sensor_dist[1] || sensor_dist[0] == sensor_dist[2]) begin
				res.distance = sensor_dist[0];
				res.chosen   = 1'b1;
			end else if (sensor_dist[1] == sensor_dist[2]) begin
				res.distance = sensor_dist[2];
				res.chosen   = 1'b1;
			end else if (diff > max_jump) begin
				res.distance = dw;
				res.chosen   = 1'b1;
			end
		end
	end

endmodule

>>> rtl/triple_range_frame_filter_vote_unit.sv
// triple_range_frame_filter_vote_unit: top level, input stage, sensor table and result register.
// Depends on trffv_pkg, trffv_frame and trffv_vote.
//
//  channel | signals                          | beat
//  in      | in_valid, in_stall, in_data      | one item: action, sensor, data_byte
//  out     | out_valid, out_stall, out_data   | one result per end of round
//  cfg     | cfg_valid, cfg_ready, cfg_index,  | one register write
//          | cfg_data                         |
//
// an item is registered on acceptance and processed when it advances out of that register, so a
// result is registered when its end-of-round item advances; one item per cycle is sustained while in_stall is low.
// in_stall rises only while an end-of-round item waits behind a full, stalled result register.
// reset clears the frame collector, sensor table, last choice and config to defaults.
// cfg_ready is always high.

module triple_range_frame_filter_vote_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  trffv_pkg::item_t              in_data,
	output logic                          out_valid,
	input  logic                          out_stall,
	output trffv_pkg::result_t            out_data,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [2:0]                    cfg_index,
	input  logic [15:0]                   cfg_data
);

	localparam int DW = trffv_pkg::DIST_W;

	logic [7:0]    header_q;
	logic [DW-1:0] min_q;
	logic [DW-1:0] span_q;
	logic [DW-1:0] hyst_q;
	logic [DW-1:0] jump_q;

	logic                                valid_s1;
	trffv_pkg::item_t                    item_s1;
	trffv_pkg::dist_vec_t                dist_q;
	logic [trffv_pkg::SENSOR_COUNT-1:0]  upd_q;
	logic [DW-1:0]                       last_q;
	logic                                out_valid_q;
	trffv_pkg::result_t                  out_q;

	logic                  is_round;
	logic                  advance;
	logic                  accept;
	logic                  sensor_ok;
	logic [1:0]            sel;
	logic [DW-1:0]         old_dist;
	logic [DW-1:0]         nd;
	logic                  in_range;
	logic                  moved;
	logic                  take;
	trffv_pkg::frame_evt_t evt;
	trffv_pkg::result_t    vote_res;

	// config port
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_q <= 8'd89;
			min_q    <= 16'd0;
			span_q   <= 16'd1400;
			hyst_q   <= 16'd2;
			jump_q   <= 16'd10;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				trffv_pkg::REG_HEADER:   header_q <= cfg_data[7:0];
				trffv_pkg::REG_MIN_DIST: min_q    <= cfg_data;
				trffv_pkg::REG_MAX_SPAN: span_q   <= cfg_data;
				trffv_pkg::REG_HYST:     hyst_q   <= cfg_data;
				trffv_pkg::REG_MAX_JUMP: jump_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// input stage and flow control
	assign is_round = item_s1.action == trffv_pkg::ACT_ROUND;
	assign advance  = valid_s1 && !(is_round && out_valid_q && out_stall);
	assign in_stall = valid_s1 && !advance;
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (accept)
			valid_s1 <= 1'b1;
		else if (advance)
			valid_s1 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (accept)
			item_s1 <= in_data;
	end

	trffv_frame u_frame (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (advance),
		.item        (item_s1),
		.header_byte (header_q),
		.evt         (evt)
	);

	// sensor table update
	assign sensor_ok = item_s1.sensor < 2'(trffv_pkg::SENSOR_COUNT);
	assign sel       = item_s1.sensor;
	assign old_dist  = sensor_ok ? dist_q[sel] : '0;
	assign nd        = evt.frame_dist;
	assign in_range  = nd >= min_q && {1'b0, nd} <= {1'b0, min_q} + {1'b0, span_q};
	// hysteresis tested in 17 bits so neither side wraps
	assign moved     = ({1'b0, nd} >= {1'b0, old_dist} + {1'b0, hyst_q})
	                || ({1'b0, nd} + {1'b0, hyst_q} <= {1'b0, old_dist});
	assign take      = nd != old_dist && in_range && moved;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dist_q <= '0;
			upd_q  <= '0;
		end else if (advance && sensor_ok) begin
			if (evt.done) begin
				if (!evt.hdr_ok) begin
					upd_q[sel] <= 1'b0;
				end else if (evt.sum_ok) begin
					upd_q[sel] <= take;
					if (take)
						dist_q[sel] <= nd;
				end
			end else if (item_s1.action == trffv_pkg::ACT_FAIL) begin
				upd_q[sel] <= 1'b0;
			end
		end
	end

	trffv_vote u_vote (
		.sensor_dist (dist_q),
		.updated     (upd_q),
		.last_choice (last_q),
		.max_jump    (jump_q),
		.res         (vote_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			last_q <= '0;
		else if (advance && is_round && vote_res.chosen)
			last_q <= vote_res.distance;
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (advance && is_round)
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (advance && is_round)
			out_q <= vote_res;
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// checks
	a_none_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.chosen |-> out_data.distance == trffv_pkg::NONE_DIST)
		else $error("non-chosen result without none code");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && is_round && out_valid_q && out_stall)
		else $error("input stalled without a blocked round result");

	a_last_choice: assert property (@(posedge clk) disable iff (!arst_n)
		advance && is_round && vote_res.chosen |=> last_q == $past(vote_res.distance))
		else $error("last choice not recorded");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_stall |=> out_valid_q && $stable(out_q))
		else $error("stalled result register changed");

endmodule

>>> sim/triple_range_frame_filter_vote_unit_tb.sv
// triple_range_frame_filter_vote_unit_tb: self-checking bench for the range frame filter and vote unit.
// Depends on trffv_pkg and triple_range_frame_filter_vote_unit; frames and rounds go in
// as queued beats, and each round's vote is predicted and checked against the result beats.

module triple_range_frame_filter_vote_unit_tb;

	localparam int          LIMIT_CYCLES  = 400000;
	localparam int          SETTLE_CYCLES = 8;
	localparam int          DRAIN_CYCLES  = 10;
	localparam int          HOLD_CYCLES   = 400;
	localparam logic [1:0]  ACT_UNUSED    = 2'd3;
	localparam logic [1:0]  NO_SENSOR     = 2'd3;

	typedef enum logic [1:0] {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;
	typedef enum logic [1:0] {FRAME_GOOD, FRAME_BAD_HEADER, FRAME_BAD_SUM} frame_kind_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	trffv_pkg::item_t   in_data = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	trffv_pkg::result_t out_data;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [2:0]         cfg_index = '0;
	logic [15:0]        cfg_data = '0;

	idle_mode_t  idle_mode = IDLE_NONE;
	logic        squeeze_go = 1'b0;
	logic        hold_all = 1'b0;
	int          errors = 0;
	int          cycles = 0;
	int          fed_items = 0;

	trffv_pkg::item_t   pending_items[$];
	trffv_pkg::result_t expected_votes[$];

	// register mirror
	logic [7:0]  c_header;
	logic [15:0] c_min, c_span, c_hyst, c_jump;

	// predicted block state
	logic [3:0]  fr_count;
	logic [7:0]  fr_sum;
	logic        fr_hdr_ok;
	logic [7:0]  fr_lo, fr_hi;
	logic [15:0] held_dist[trffv_pkg::SENSOR_COUNT];
	logic        held_fresh[trffv_pkg::SENSOR_COUNT];
	logic [15:0] prev_choice;

	// distances that most random frames draw from
	logic [15:0] dist_pool[4];
	int          pool_lo, pool_hi;

	triple_range_frame_filter_vote_unit DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic void clear_frame();
		fr_count  = '0;
		fr_sum    = '0;
		fr_hdr_ok = 1'b1;
		fr_lo     = '0;
		fr_hi     = '0;
	endfunction

	function automatic void store_distance(logic [1:0] s, logic [15:0] nd);
		logic [16:0] top;
		logic [16:0] old;
		logic        ok;
		top = {1'b0, c_min} + {1'b0, c_span};
		old = {1'b0, held_dist[s]};
		ok  = 1'b0;
		if (nd != held_dist[s] && nd >= c_min && {1'b0, nd} <= top) begin
			// hysteresis compared in 17 bits so nothing wraps
			if ({1'b0, nd} >= old + {1'b0, c_hyst} || {1'b0, nd} + {1'b0, c_hyst} <= old) begin
				held_dist[s] = nd;
				ok = 1'b1;
			end
		end
		held_fresh[s] = ok;
	endfunction

	function automatic void collect_byte(logic [1:0] s, logic [7:0] b);
		if (fr_count < 2 && b != c_header)
			fr_hdr_ok = 1'b0;
		if (fr_count == 2)
			fr_lo = b;
		if (fr_count == 3)
			fr_hi = b;
		if (fr_count + 1 < trffv_pkg::FRAME_BYTES) begin
			fr_sum   = fr_sum + b;
			fr_count = fr_count + 4'd1;
		end else begin
			// the ninth byte's sensor owns the whole frame
			if (s < trffv_pkg::SENSOR_COUNT) begin
				if (!fr_hdr_ok)
					held_fresh[s] = 1'b0;
				else if (b == fr_sum)
					store_distance(s, {fr_hi, fr_lo});
			end
			clear_frame();
		end
	endfunction

	function automatic trffv_pkg::result_t cast_vote();
		trffv_pkg::result_t r;
		logic               any;
		int                 w;
		logic [15:0]        dw, gap;
		any = 1'b0;
		w   = 0;
		for (int i = 0; i < trffv_pkg::SENSOR_COUNT; i++) begin
			if (held_fresh[i]) begin
				any = 1'b1;
				w   = i;
			end
		end
		r.distance = trffv_pkg::NONE_DIST;
		r.chosen   = 1'b0;
		if (any) begin
			if (held_dist[0] == held_dist[1] || held_dist[0] == held_dist[2]) begin
				r.distance = held_dist[0];
				r.chosen   = 1'b1;
			end else if (held_dist[1] == held_dist[2]) begin
				r.distance = held_dist[2];
				r.chosen   = 1'b1;
			end else begin
				dw  = held_dist[w];
				gap = (dw >= prev_choice) ? dw - prev_choice : prev_choice - dw;
				if (gap > c_jump) begin
					r.distance = dw;
					r.chosen   = 1'b1;
				end
			end
		end
		if (r.chosen)
			prev_choice = r.distance;
		return r;
	endfunction

	function automatic void predict_item(trffv_pkg::item_t it);
		case (it.action)
			trffv_pkg::ACT_BYTE: begin
				collect_byte(it.sensor, it.data_byte);
			end
			trffv_pkg::ACT_FAIL: begin
				if (it.sensor < trffv_pkg::SENSOR_COUNT)
					held_fresh[it.sensor] = 1'b0;
				clear_frame();
			end
			trffv_pkg::ACT_ROUND: begin
				clear_frame();
				expected_votes.push_back(cast_vote());
			end
			default: ;
		endcase
	endfunction

	function automatic logic sender_rests();
		case (idle_mode)
			IDLE_SEND: return $urandom_range(0, 99) < 73;
			IDLE_BOTH: return $urandom_range(0, 99) < 9;
			default:   return 1'b0;
		endcase
	endfunction

	function automatic logic receiver_rests();
		case (idle_mode)
			IDLE_RECV: return $urandom_range(0, 99) < 73;
			IDLE_BOTH: return $urandom_range(0, 99) < 9;
			default:   return 1'b0;
		endcase
	endfunction

	// input driver: a stalled beat holds, otherwise the next queued item may go out
	always @(posedge clk) begin : drive
		logic             go;
		trffv_pkg::item_t nxt;
		go = in_valid;
		if (in_valid && !in_stall) begin
			predict_item(in_data);
			go = 1'b0;
		end
		if (!go && pending_items.size() > 0 && !sender_rests()) begin
			nxt = pending_items.pop_front();
			in_data <= nxt;
			go = 1'b1;
		end
		in_valid <= go;
	end

	// result monitor
	always @(posedge clk) begin : watch
		trffv_pkg::result_t want;
		if (out_valid && !out_stall) begin
			if (expected_votes.size() == 0) begin
				$error("unexpected result beat: distance %0d chosen %0d",
					out_data.distance, out_data.chosen);
				errors++;
			end else begin
				want = expected_votes.pop_front();
				if (out_data.distance !== want.distance) begin
					$error("distance: expected %0d, got %0d", want.distance, out_data.distance);
					errors++;
				end
				if (out_data.chosen !== want.chosen) begin
					$error("chosen: expected %0d, got %0d", want.chosen, out_data.chosen);
					errors++;
				end
			end
		end
		out_stall <= hold_all || receiver_rests();
	end

	// long receiver hold-off so the result register fills and input stalls
	initial begin
		@(posedge clk);
		while (!squeeze_go)
			@(posedge clk);
		hold_all <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_all <= 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT_CYCLES) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	task automatic push_item(int a, int s, int b);
		trffv_pkg::item_t it;
		it.action    = 2'(a);
		it.sensor    = 2'(s);
		it.data_byte = 8'(b);
		pending_items.push_back(it);
		if (it.action != ACT_UNUSED)
			fed_items++;
	endtask

	task automatic push_frame(int s, logic [15:0] d, frame_kind_t kind, int keep);
		logic [7:0] b[trffv_pkg::FRAME_BYTES];
		logic [7:0] sum;
		logic [7:0] flip;
		int         k;
		b[0] = c_header;
		b[1] = c_header;
		b[2] = d[7:0];
		b[3] = d[15:8];
		for (k = 4; k < trffv_pkg::FRAME_BYTES - 1; k++)
			b[k] = 8'($urandom);
		flip = 8'($urandom_range(1, 255));
		if (kind == FRAME_BAD_HEADER) begin
			k = int'($urandom_range(0, 1));
			b[k] = b[k] ^ flip;
		end
		sum = '0;
		for (k = 0; k < trffv_pkg::FRAME_BYTES - 1; k++)
			sum = sum + b[k];
		b[trffv_pkg::FRAME_BYTES-1] = (kind == FRAME_BAD_SUM) ? sum ^ flip : sum;
		// leading bytes may name any sensor, only the last one counts
		for (k = 0; k < keep; k++)
			push_item(trffv_pkg::ACT_BYTE,
				(k == trffv_pkg::FRAME_BYTES - 1) ? s : int'($urandom_range(0, 3)),
				int'(b[k]));
	endtask

	function automatic int clamp_pool(int v);
		if (v < pool_lo)
			return pool_lo;
		if (v > pool_hi)
			return pool_hi;
		return v;
	endfunction

	task automatic new_pool();
		int base;
		pool_lo = int'(c_min);
		pool_hi = int'(c_min) + int'(c_span);
		if (pool_hi > 65535)
			pool_hi = 65535;
		base = pool_lo + int'($urandom_range(0, pool_hi - pool_lo));
		dist_pool[0] = 16'(base);
		dist_pool[1] = 16'(clamp_pool(base + int'(c_hyst)));
		dist_pool[2] = 16'(clamp_pool(base + int'(c_hyst) - 1));
		dist_pool[3] = 16'(pool_lo + int'($urandom_range(0, pool_hi - pool_lo)));
	endtask

	function automatic logic [15:0] pick_distance();
		int r;
		r = int'($urandom_range(0, 99));
		if (r < 70)
			return dist_pool[$urandom_range(0, 3)];
		if (r < 78)
			return 16'(pool_lo);
		if (r < 86)
			return 16'(pool_hi);
		return 16'($urandom);
	endfunction

	task automatic write_reg(trffv_pkg::reg_index_t idx, logic [15:0] v);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= v;
		do
			@(posedge clk);
		while (!cfg_ready);
		case (idx)
			trffv_pkg::REG_HEADER:   c_header = v[7:0];
			trffv_pkg::REG_MIN_DIST: c_min    = v;
			trffv_pkg::REG_MAX_SPAN: c_span   = v;
			trffv_pkg::REG_HYST:     c_hyst   = v;
			trffv_pkg::REG_MAX_JUMP: c_jump   = v;
			default: ;
		endcase
	endtask

	task automatic settle(int extra);
		while (pending_items.size() != 0 || in_valid || expected_votes.size() != 0)
			@(posedge clk);
		repeat (extra) @(posedge clk);
	endtask

	task automatic run_random(int n);
		int          target, r, q, s, keep;
		frame_kind_t kind;
		target = fed_items + n;
		while (fed_items < target) begin
			r = int'($urandom_range(0, 99));
			s = ($urandom_range(0, 99) < 6) ? int'(NO_SENSOR) : int'($urandom_range(0, 2));
			if (r < 55) begin
				q    = int'($urandom_range(0, 99));
				kind = (q < 8) ? FRAME_BAD_SUM : (q < 16) ? FRAME_BAD_HEADER : FRAME_GOOD;
				keep = (q >= 94) ? int'($urandom_range(1, trffv_pkg::FRAME_BYTES - 1))
					: trffv_pkg::FRAME_BYTES;
				push_frame(s, pick_distance(), kind, keep);
			end else if (r < 75)
				push_item(trffv_pkg::ACT_ROUND, int'($urandom_range(0, 3)),
					int'($urandom_range(0, 255)));
			else if (r < 83)
				push_item(trffv_pkg::ACT_FAIL, s, int'($urandom_range(0, 255)));
			else if (r < 92)
				push_item(trffv_pkg::ACT_BYTE, s, int'($urandom_range(0, 255)));
			else if (r < 96)
				push_item(ACT_UNUSED, int'($urandom_range(0, 3)), int'($urandom_range(0, 255)));
			else
				push_item(int'($urandom_range(0, 3)), int'($urandom_range(0, 3)),
					int'($urandom_range(0, 255)));
		end
	endtask

	task automatic run_phase(idle_mode_t m, logic [7:0] h, logic [15:0] mn, logic [15:0] sp,
		logic [15:0] hy, logic [15:0] jp, int n, logic squeeze);
		settle(SETTLE_CYCLES);
		write_reg(trffv_pkg::REG_HEADER, {8'h00, h});
		write_reg(trffv_pkg::REG_MIN_DIST, mn);
		write_reg(trffv_pkg::REG_MAX_SPAN, sp);
		write_reg(trffv_pkg::REG_HYST, hy);
		write_reg(trffv_pkg::REG_MAX_JUMP, jp);
		cfg_valid <= 1'b0;
		new_pool();
		idle_mode <= m;
		if (squeeze)
			squeeze_go <= 1'b1;
		run_random(n);
	endtask

	initial begin
		c_header = 8'd89;
		c_min    = 16'd0;
		c_span   = 16'd1400;
		c_hyst   = 16'd2;
		c_jump   = 16'd10;
		clear_frame();
		for (int i = 0; i < trffv_pkg::SENSOR_COUNT; i++) begin
			held_dist[i]  = '0;
			held_fresh[i] = 1'b0;
		end
		prev_choice = '0;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset values: top of range, header mismatch, failures, ignored action,
		// extreme bytes and a partial frame dropped by the round
		push_frame(0, 16'd1400, FRAME_GOOD, trffv_pkg::FRAME_BYTES);
		push_item(trffv_pkg::ACT_ROUND, 0, 0);
		push_frame(0, 16'd700, FRAME_BAD_HEADER, trffv_pkg::FRAME_BYTES);
		push_item(trffv_pkg::ACT_FAIL, 2, 0);
		push_item(trffv_pkg::ACT_FAIL, NO_SENSOR, 8'hff);
		push_item(ACT_UNUSED, NO_SENSOR, 8'hff);
		push_item(trffv_pkg::ACT_BYTE, 1, 8'hff);
		push_item(trffv_pkg::ACT_BYTE, 1, 8'h00);
		push_item(trffv_pkg::ACT_ROUND, NO_SENSOR, 8'hff);

		run_phase(IDLE_NONE, 8'd89, 16'd300, 16'd500, 16'd5, 16'd20, 250, 1'b1);
		run_phase(IDLE_SEND, 8'h00, 16'd0, 16'hffff, 16'd0, 16'd0, 250, 1'b0);
		run_phase(IDLE_RECV, 8'hff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 200, 1'b0);
		run_phase(IDLE_BOTH, 8'haa, 16'd1000, 16'd0, 16'd1, 16'hffff, 200, 1'b0);
		run_phase(IDLE_RECV, 8'd89, 16'd0, 16'd1400, 16'd2, 16'd10, 250, 1'b0);
		run_phase(IDLE_SEND, 8'($urandom_range(0, 255)), 16'($urandom_range(0, 2000)),
			16'($urandom_range(0, 65535)), 16'($urandom_range(0, 8)),
			16'($urandom_range(0, 500)), 250, 1'b0);
		run_phase(IDLE_NONE, 8'h5a, 16'd20, 16'd3000, 16'd0, 16'd65534, 325, 1'b0);

		settle(DRAIN_CYCLES);
		if (errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
